FILE: rtl/core/rtd_resistance_to_temperature_core_assert.svh
// Assertion macros shared by the RTD temperature core
`ifndef RTD_RESISTANCE_TO_TEMPERATURE_CORE_ASSERT_SVH
`define RTD_RESISTANCE_TO_TEMPERATURE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtd core assertion failed");

// delayed implication, disabled in reset
`define RTD_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("rtd core assertion failed");

`endif

FILE: rtl/core/rtd_pkg.sv
// Types and constants of the RTD resistance to temperature core
`default_nettype none
package rtd_pkg;

  localparam int OHM_W    = 16;
  localparam int TEMP_W   = 19;
  localparam int ROOT_W   = 28;
  localparam int DISC_W   = 2 * ROOT_W;
  localparam int DISC_SW  = 58;
  localparam int AQ_W     = 25;
  localparam int KQ_W     = 40;
  localparam int KQ_SPLIT = 20;
  localparam int DEN_W    = 39;
  localparam int R0       = 1000;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [1:0] SENSOR_NONE = 2'd0;
  localparam logic [1:0] SENSOR_PT   = 2'd1;
  localparam logic [1:0] SENSOR_NI   = 2'd2;

  localparam logic REG_SENSOR_TYPE = 1'b0;

  // A at scale 2^32, 4B/R0 at scale 2^64
  localparam logic [AQ_W-1:0]        PT_AQ = 25'd16783642;
  localparam logic [AQ_W-1:0]        NI_AQ = 25'd23557896;
  localparam logic signed [KQ_W-1:0] PT_KQ = -40'sd42609138012;
  localparam logic signed [KQ_W-1:0] NI_KQ = 40'sd490683392361;
  localparam logic [DISC_SW-1:0]     PT_AQ2 = DISC_SW'(PT_AQ) * DISC_SW'(PT_AQ);
  localparam logic [DISC_SW-1:0]     NI_AQ2 = DISC_SW'(NI_AQ) * DISC_SW'(NI_AQ);

  localparam int unsigned TEMP_POS_LIM = 262143;
  localparam int unsigned TEMP_NEG_LIM = 131072;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd131072;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_TYPE,
    ST_NO_ROOT,
    ST_CLAMPED
  } status_e;

  typedef struct packed {
    logic             no_type;
    logic             no_root;
    logic             neg;
    logic             ni;
    logic [OHM_W-1:0] mag;
  } meta_t;

endpackage
`default_nettype wire

FILE: rtl/core/rtd_resistance_to_temperature_core.sv
// Top level of the RTD resistance to temperature core
//
// Turns a resistance in whole ohms into a temperature in 2^-TEMP_FRAC_BITS
// degC via the quadratic Callendar-Van Dusen inverse, Pt1000 or Ni1000.
// Input: an item (ohm_i) is taken at each clock edge with start high and
//   busy low. busy is never raised, so an item may enter every cycle.
// Output: done_o marks temperature_o and status_o for exactly one cycle;
//   items leave in order; one per cycle. The pipeline is made of the cell
//   chains: two discriminant stages, 28 square root cells, two stages
//   forming divisor and rounded dividend, 16 + TEMP_FRAC_BITS divider
//   cells and the clamp/output register.
// Config: APB register 0 (address 0) holds sensor_type; write only while
//   no item is in flight. pready is always high.
// Reset clears sensor_type (no sensor) and drops all items in flight.
// The receiver cannot stall: each result must be taken when done_o is high.
`default_nettype none
`include "rtd_resistance_to_temperature_core_assert.svh"
module rtd_resistance_to_temperature_core #(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [rtd_pkg::OHM_W-1:0]         ohm_i,
  output logic                              done_o,
  output logic signed [rtd_pkg::TEMP_W-1:0] temperature_o,
  output logic [1:0]                        status_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [rtd_pkg::ADDR_W-1:0]        paddr,
  input  wire  [rtd_pkg::DATA_W-1:0]        pwdata,
  output logic [rtd_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import rtd_pkg::*;

  localparam int QW     = 16 + TEMP_FRAC_BITS;
  localparam int NUM_SH = 32 + TEMP_FRAC_BITS;
  localparam int N_W    = OHM_W + 2 + NUM_SH;
  localparam int REM_W  = DEN_W + QW;
  localparam int LAT    = ROOT_W + QW + 5;
  localparam logic [QW-1:0] POS_LIM = QW'(TEMP_POS_LIM);
  localparam logic [QW-1:0] NEG_LIM = QW'(TEMP_NEG_LIM);

  logic       accept;
  logic       cfg_wr;
  logic [1:0] sensor_type_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_type_q <= SENSOR_NONE;
    end else if (cfg_wr && (paddr[ADDR_W-1] == REG_SENSOR_TYPE)) begin
      sensor_type_q <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_SENSOR_TYPE) ?
                  {{(DATA_W-2){1'b0}}, sensor_type_q} : '0;

  // discriminant
  logic              sq_valid [ROOT_W+1];
  meta_t             sq_meta  [ROOT_W+1];
  logic [DISC_W-1:0] sq_rem   [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root  [ROOT_W+1];

  rtd_disc u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .sensor_i (sensor_type_q),
    .ohm_i    (ohm_i),
    .valid_o  (sq_valid[0]),
    .meta_o   (sq_meta[0]),
    .disc_o   (sq_rem[0])
  );
  assign sq_root[0] = '0;

  // square root chain, one root bit per cell
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    rtd_sqrt_cell #(
      .BIT (ROOT_W - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[i]),
      .meta_i  (sq_meta[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .valid_o (sq_valid[i+1]),
      .meta_o  (sq_meta[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1])
    );
  end

  // divisor R0*(A + s)
  logic [ROOT_W:0]  aq_s;
  logic [DEN_W-1:0] den_d;
  logic             dv_q;
  meta_t            dm_q;
  logic [DEN_W-1:0] den_q;

  always_comb begin
    aq_s  = (ROOT_W+1)'(sq_meta[ROOT_W].ni ? NI_AQ : PT_AQ) +
            (ROOT_W+1)'(sq_root[ROOT_W]);
    den_d = DEN_W'(aq_s) * DEN_W'(R0);
  end

  // rounded dividend 2*|d|*2^(32+F) + den/2
  logic [N_W-1:0]   n_d;
  logic             nv_q;
  meta_t            nm_q;
  logic [DEN_W-1:0] nden_q;
  logic [N_W-1:0]   n_q;

  assign n_d = (N_W'(dm_q.mag) << (NUM_SH + 1)) + N_W'(den_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
      nv_q <= 1'b0;
    end else begin
      dv_q <= sq_valid[ROOT_W];
      nv_q <= dv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dm_q   <= sq_meta[ROOT_W];
    den_q  <= den_d;
    nm_q   <= dm_q;
    nden_q <= den_q;
    n_q    <= n_d;
  end

  // divider chain, one quotient bit per cell
  logic             dq_valid [QW+1];
  meta_t            dq_meta  [QW+1];
  logic [REM_W-1:0] dq_rem   [QW+1];
  logic [DEN_W-1:0] dq_den   [QW+1];
  logic [QW-1:0]    dq_quo   [QW+1];

  assign dq_valid[0] = nv_q;
  assign dq_meta[0]  = nm_q;
  assign dq_rem[0]   = REM_W'(n_q);
  assign dq_den[0]   = nden_q;
  assign dq_quo[0]   = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    rtd_div_cell #(
      .REM_W (REM_W),
      .QW    (QW),
      .BIT   (QW - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dq_valid[j]),
      .meta_i  (dq_meta[j]),
      .rem_i   (dq_rem[j]),
      .den_i   (dq_den[j]),
      .quo_i   (dq_quo[j]),
      .valid_o (dq_valid[j+1]),
      .meta_o  (dq_meta[j+1]),
      .rem_o   (dq_rem[j+1]),
      .den_o   (dq_den[j+1]),
      .quo_o   (dq_quo[j+1])
    );
  end

  // sign, clamp and status
  meta_t                     om;
  logic [QW-1:0]             quo;
  logic [TEMP_W-1:0]         tmag;
  logic signed [TEMP_W-1:0]  temp_d;
  status_e                   status_d;
  logic                      out_valid_q;
  logic signed [TEMP_W-1:0]  temp_q;
  status_e                   status_q;

  always_comb begin
    om   = dq_meta[QW];
    quo  = dq_quo[QW];
    tmag = quo[TEMP_W-1:0];
    priority if (om.no_type) begin
      temp_d   = '0;
      status_d = ST_NO_TYPE;
    end else if (om.no_root) begin
      temp_d   = '0;
      status_d = ST_NO_ROOT;
    end else if (om.neg && (quo > NEG_LIM)) begin
      temp_d   = TEMP_MIN;
      status_d = ST_CLAMPED;
    end else if (!om.neg && (quo > POS_LIM)) begin
      temp_d   = TEMP_MAX;
      status_d = ST_CLAMPED;
    end else begin
      temp_d   = om.neg ? $signed(~tmag + 1'b1) : $signed(tmag);
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dq_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q   <= temp_d;
    status_q <= status_d;
  end

  assign done_o        = out_valid_q;
  assign temperature_o = temp_q;
  assign status_o      = status_q;

  `RTD_ASSERT_DLY(a_latency, accept, LAT, done_o)
  `RTD_ASSERT_DLY(a_no_spurious, !accept, LAT, !done_o)
  `RTD_ASSERT_DLY(a_no_type, accept && (sensor_type_q == SENSOR_NONE), LAT, status_o == ST_NO_TYPE && temperature_o == '0)
  `RTD_ASSERT_IMP(a_clamp_bound, done_o && status_o == ST_CLAMPED, temperature_o == TEMP_MAX || temperature_o == TEMP_MIN)

endmodule
`default_nettype wire

FILE: rtl/core/rtd_disc.sv
// Two-stage discriminant unit: A^2 + (4B/R0)*(ohm - R0) at scale 2^64
`default_nettype none
module rtd_disc (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       valid_i,
  input  wire  [1:0]                sensor_i,
  input  wire  [rtd_pkg::OHM_W-1:0] ohm_i,
  output logic                      valid_o,
  output rtd_pkg::meta_t            meta_o,
  output logic [rtd_pkg::DISC_W-1:0] disc_o
);
  import rtd_pkg::*;

  localparam int HI_W = KQ_W - KQ_SPLIT;

  logic                         ni;
  logic signed [KQ_W-1:0]       kq;
  logic signed [HI_W-1:0]       kq_hi;
  logic signed [KQ_SPLIT:0]     kq_lo;
  logic signed [OHM_W:0]        d;
  meta_t                        ma_d;
  logic signed [HI_W+OHM_W:0]   phi_d, phi_q;
  logic signed [KQ_SPLIT+OHM_W+1:0] plo_d, plo_q;
  logic                         va_q;
  meta_t                        ma_q;
  logic signed [DISC_SW-1:0]    aq2_s, hi_s, lo_s, disc_s;
  logic                         vb_q;
  meta_t                        mb_d;
  meta_t                        mb_q;
  logic [DISC_W-1:0]            disc_q;

  always_comb begin
    ni    = (sensor_i == SENSOR_NI);
    kq    = ni ? NI_KQ : PT_KQ;
    kq_hi = kq[KQ_W-1:KQ_SPLIT];
    kq_lo = {1'b0, kq[KQ_SPLIT-1:0]};
    d     = $signed({1'b0, ohm_i}) - $signed((OHM_W+1)'(R0));
    phi_d = kq_hi * d;
    plo_d = kq_lo * d;
    ma_d.no_type = !((sensor_i == SENSOR_PT) || ni);
    ma_d.no_root = 1'b0;
    ma_d.neg     = d[OHM_W];
    ma_d.ni      = ni;
    ma_d.mag     = d[OHM_W] ? OHM_W'(-d) : d[OHM_W-1:0];
  end

  always_comb begin
    aq2_s  = $signed(ma_q.ni ? NI_AQ2 : PT_AQ2);
    hi_s   = DISC_SW'(phi_q) <<< KQ_SPLIT;
    lo_s   = DISC_SW'(plo_q);
    disc_s = aq2_s + hi_s + lo_s;
    mb_d         = ma_q;
    mb_d.no_root = disc_s[DISC_SW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    phi_q  <= phi_d;
    plo_q  <= plo_d;
    mb_q   <= mb_d;
    disc_q <= disc_s[DISC_W-1:0];
  end

  assign valid_o = vb_q;
  assign meta_o  = mb_q;
  assign disc_o  = disc_q;

endmodule
`default_nettype wire

FILE: rtl/core/rtd_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage
`default_nettype none
module rtd_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         valid_i,
  input  rtd_pkg::meta_t              meta_i,
  input  wire  [rtd_pkg::DISC_W-1:0]  rem_i,
  input  wire  [rtd_pkg::ROOT_W-1:0]  root_i,
  output logic                        valid_o,
  output rtd_pkg::meta_t              meta_o,
  output logic [rtd_pkg::DISC_W-1:0]  rem_o,
  output logic [rtd_pkg::ROOT_W-1:0]  root_o
);
  import rtd_pkg::*;

  logic [DISC_W:0]   trial;
  logic              ge;
  logic [DISC_W-1:0] rem_d;
  logic [ROOT_W-1:0] root_d;

  always_comb begin
    trial  = ((DISC_W+1)'(root_i) << (BIT + 1)) | ((DISC_W+1)'(1) << (2 * BIT));
    ge     = {1'b0, rem_i} >= trial;
    rem_d  = ge ? rem_i - trial[DISC_W-1:0] : rem_i;
    root_d = ge ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_o <= meta_i;
    rem_o  <= rem_d;
    root_o <= root_d;
  end

endmodule
`default_nettype wire

FILE: rtl/core/rtd_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit per stage
`default_nettype none
module rtd_div_cell #(
  parameter int REM_W = 63,
  parameter int QW    = 24,
  parameter int BIT   = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  input  rtd_pkg::meta_t             meta_i,
  input  wire  [REM_W-1:0]           rem_i,
  input  wire  [rtd_pkg::DEN_W-1:0]  den_i,
  input  wire  [QW-1:0]              quo_i,
  output logic                       valid_o,
  output rtd_pkg::meta_t             meta_o,
  output logic [REM_W-1:0]           rem_o,
  output logic [rtd_pkg::DEN_W-1:0]  den_o,
  output logic [QW-1:0]              quo_o
);
  import rtd_pkg::*;

  logic [REM_W-1:0] trial;
  logic             ge;
  logic [REM_W-1:0] rem_d;
  logic [QW-1:0]    quo_d;

  always_comb begin
    trial = REM_W'(den_i) << BIT;
    ge    = rem_i >= trial;
    rem_d = ge ? rem_i - trial : rem_i;
    quo_d = ge ? (quo_i | (QW'(1) << BIT)) : quo_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_o <= meta_i;
    rem_o  <= rem_d;
    den_o  <= den_i;
    quo_o  <= quo_d;
  end

endmodule
`default_nettype wire
